// ===== rtl/multiturn_angle_position_tracker_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multiturn angle position tracker checker
// ----------------------------------------------------------------------------
`ifndef MULTITURN_ANGLE_POSITION_TRACKER_CORE_MACROS_SVH
`define MULTITURN_ANGLE_POSITION_TRACKER_CORE_MACROS_SVH

// Clocked property, muted while reset is high.
`define MAPT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mapt checker: property failed");

// Clocked property that is also checked across reset.
`define MAPT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mapt checker: property failed");

`endif

// ===== rtl/mapt_pkg.sv =====
// ----------------------------------------------------------------------------
// mapt_pkg
// Types, codes and constants shared by the multiturn position tracker.
// ----------------------------------------------------------------------------
package mapt_pkg;

  localparam int AngleW = 12;
  localparam int PosW   = 32;
  localparam int RevW   = 20;
  localparam int DataW  = 32;
  localparam int AddrW  = 3;

  localparam logic [AngleW-1:0] HalfTurn = 12'd2048;

  typedef logic [AngleW-1:0]      angle_t;
  typedef logic signed [PosW-1:0] pos_t;
  typedef logic signed [RevW-1:0] rev_t;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_REUSE  = 2'd1,
    OP_LOAD   = 2'd2,
    OP_RESEED = 2'd3
  } opcode_t;

  typedef enum logic {
    REG_ANGLE_OFFSET      = 1'b0,
    REG_REVERSE_DIRECTION = 1'b1
  } reg_idx_t;

  typedef struct packed {
    angle_t angle_offset;
    logic   reverse_direction;
  } cfg_t;

  typedef struct packed {
    angle_t held_angle;
    angle_t tracking_angle;
    pos_t   position;
  } track_state_t;

  typedef struct packed {
    opcode_t opcode;
    angle_t  enc_angle;
    logic    read_error;
    pos_t    load_value;
  } sample_t;

  typedef struct packed {
    angle_t angle;
    pos_t   position;
    rev_t   revolutions;
    pos_t   previous_position;
  } result_t;

endpackage

// ===== rtl/mapt_sample_if.sv =====
// ----------------------------------------------------------------------------
// mapt_sample_if
// Input channel: one encoder sample or load command per transaction.
// ----------------------------------------------------------------------------
interface mapt_sample_if;
  import mapt_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  angle_t  enc_angle;
  logic    read_error;
  pos_t    load_value;

  modport source (output valid, output opcode, output enc_angle, output read_error,
                  output load_value, input ready);
  modport sink   (input valid, input opcode, input enc_angle, input read_error,
                  input load_value, output ready);
endinterface

// ===== rtl/mapt_result_if.sv =====
// ----------------------------------------------------------------------------
// mapt_result_if
// Output channel: angle and multi-turn position per transaction.
// ----------------------------------------------------------------------------
interface mapt_result_if;
  import mapt_pkg::*;

  logic   valid;
  logic   ready;
  angle_t angle;
  pos_t   position;
  rev_t   revolutions;
  pos_t   previous_position;

  modport source (output valid, output angle, output position, output revolutions,
                  output previous_position, input ready);
  modport sink   (input valid, input angle, input position, input revolutions,
                  input previous_position, output ready);
endinterface

// ===== rtl/mapt_cfg.sv =====
// ----------------------------------------------------------------------------
// mapt_cfg
// APB register file holding the angle offset and direction setting.
// ----------------------------------------------------------------------------
module mapt_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mapt_pkg::AddrW-1:0] paddr,
  input  logic [mapt_pkg::DataW-1:0] pwdata,
  output logic [mapt_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output mapt_pkg::cfg_t             cfg
);
  import mapt_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_offset      <= '0;
      cfg.reverse_direction <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_ANGLE_OFFSET:      cfg.angle_offset      <= pwdata[AngleW-1:0];
        REG_REVERSE_DIRECTION: cfg.reverse_direction <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ANGLE_OFFSET:      prdata = {{(DataW-AngleW){1'b0}}, cfg.angle_offset};
      REG_REVERSE_DIRECTION: prdata = {{(DataW-1){1'b0}}, cfg.reverse_direction};
      default:               prdata = '0;
    endcase
  end
endmodule

// ===== rtl/mapt_update.sv =====
// ----------------------------------------------------------------------------
// mapt_update
// Angle correction, wrap-aware tracking step and load handling for one item.
// ----------------------------------------------------------------------------
module mapt_update (
  input  mapt_pkg::sample_t      item,
  input  mapt_pkg::track_state_t state,
  input  mapt_pkg::cfg_t         cfg,
  output mapt_pkg::track_state_t state_next,
  output mapt_pkg::result_t      res
);
  import mapt_pkg::*;

  angle_t             sum;
  angle_t             corr;
  logic               good;
  angle_t             v;
  angle_t             t;
  logic               fwd_wrap;
  logic               bwd_wrap;
  logic signed [13:0] diff;
  logic signed [13:0] step;
  pos_t               tracked;

  always_comb begin
    sum  = item.enc_angle + cfg.angle_offset;
    // mirror as (4096 - angle) mod 4096
    corr = cfg.reverse_direction ? angle_t'(~sum + 1'b1) : sum;
    good = !item.read_error;

    v = (item.opcode == OP_REUSE) ? state.held_angle : corr;
    t = state.tracking_angle;
    fwd_wrap = (t > HalfTurn) && (v < angle_t'(t - HalfTurn));
    bwd_wrap = !fwd_wrap && (v > HalfTurn) && (t < angle_t'(v - HalfTurn));
    diff = $signed({2'b00, v}) - $signed({2'b00, t});
    if (fwd_wrap) begin
      step = diff + 14'sd4096;
    end else if (bwd_wrap) begin
      step = diff - 14'sd4096;
    end else begin
      step = diff;
    end
    tracked = state.position + pos_t'({{(PosW-14){step[13]}}, step});

    state_next = state;
    case (item.opcode)
      OP_SAMPLE: begin
        if (good) begin
          state_next.held_angle     = corr;
          state_next.tracking_angle = corr;
          state_next.position       = tracked;
        end
      end
      OP_REUSE: begin
        state_next.tracking_angle = state.held_angle;
        state_next.position       = tracked;
      end
      OP_LOAD: begin
        state_next.position = item.load_value;
      end
      OP_RESEED: begin
        // a failed read reseeds from the held angle
        if (good) begin
          state_next.held_angle = corr;
        end
        state_next.tracking_angle = good ? corr : state.held_angle;
        state_next.position       = item.load_value;
      end
      default: ;
    endcase

    res.angle    = state_next.held_angle;
    res.position = state_next.position;
    // arithmetic shift, plus one when negative
    res.revolutions = rev_t'(state_next.position[PosW-1:AngleW]
                             + {{(RevW-1){1'b0}}, state_next.position[PosW-1]});
    res.previous_position = (item.opcode == OP_LOAD || item.opcode == OP_RESEED)
                          ? state.position : state_next.position;
  end
endmodule

// ===== rtl/multiturn_angle_position_tracker_core.sv =====
// ----------------------------------------------------------------------------
// multiturn_angle_position_tracker_core: top level of the multi-turn tracker
// Stages: input reg, then result reg; state updates as an item enters the result reg.
// Throughput: 1 item per cycle while the result sink is not stalling.
// Reset (rst, synchronous): clears valids, state and configuration to zero.
// ----------------------------------------------------------------------------
module multiturn_angle_position_tracker_core (
  input  logic                       clk,
  input  logic                       rst,
  mapt_sample_if.sink                sample,
  mapt_result_if.source              result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mapt_pkg::AddrW-1:0] paddr,
  input  logic [mapt_pkg::DataW-1:0] pwdata,
  output logic [mapt_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import mapt_pkg::*;

  cfg_t         cfg;
  logic         s1_valid;
  sample_t      s1;
  logic         out_valid;
  result_t      out_data;
  track_state_t state;
  track_state_t state_next;
  result_t      res;
  logic         out_free;
  logic         s1_fire;

  mapt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mapt_update u_update (
    .item       (s1),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .res        (res)
  );

  assign out_free     = !out_valid || result.ready;
  assign s1_fire      = s1_valid && out_free;
  assign sample.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      s1.opcode     <= sample.opcode;
      s1.enc_angle  <= sample.enc_angle;
      s1.read_error <= sample.read_error;
      s1.load_value <= sample.load_value;
    end
  end

  // advance tracking state only when the item moves into the result reg
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= res;
    end
  end

  assign result.valid             = out_valid;
  assign result.angle             = out_data.angle;
  assign result.position          = out_data.position;
  assign result.revolutions       = out_data.revolutions;
  assign result.previous_position = out_data.previous_position;
endmodule

// ===== rtl/mapt_checker.sv =====
// ----------------------------------------------------------------------------
// mapt_checker
// Port-level checks on the tracker result channel and register port.
// ----------------------------------------------------------------------------
`include "multiturn_angle_position_tracker_core_macros.svh"

module mapt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       result_valid,
  input logic                       result_ready,
  input mapt_pkg::pos_t             result_position,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [mapt_pkg::AddrW-1:0] paddr,
  input logic [mapt_pkg::DataW-1:0] pwdata,
  input logic [mapt_pkg::DataW-1:0] prdata
);
  import mapt_pkg::*;

  // a stalled result stays offered
  `MAPT_ASSERT(a_valid_hold, clk, rst, result_valid && !result_ready |=> result_valid)

  // a stalled result keeps its position
  `MAPT_ASSERT(a_pos_hold, clk, rst,
    result_valid && !result_ready |=> $stable(result_position))

  // nothing comes out right after reset
  `MAPT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid)

  // offset write reads back on the next cycle
  `MAPT_ASSERT(a_offset_readback, clk, rst,
    psel && penable && pwrite && paddr[2] == REG_ANGLE_OFFSET |=>
      (paddr[2] != REG_ANGLE_OFFSET || prdata[AngleW-1:0] == $past(pwdata[AngleW-1:0])))
endmodule

bind multiturn_angle_position_tracker_core mapt_checker u_mapt_checker (
  .clk             (clk),
  .rst             (rst),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .result_position (result.position),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata)
);

// ===== verif/tb_multiturn_angle_position_tracker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiturn_angle_position_tracker_core
// Drives encoder samples and load commands with random gaps and sink stalls,
// predicts angle, multi-turn position and revolutions per transaction and
// checks every result in order across several offset and direction settings.
// ----------------------------------------------------------------------------
module tb_multiturn_angle_position_tracker_core;
  import mapt_pkg::*;

  localparam int FullTurnI = 4096;
  localparam int HalfTurnI = 2048;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  mapt_sample_if s_if ();
  mapt_result_if r_if ();

  multiturn_angle_position_tracker_core uut (
    .clk    (clk),
    .rst    (rst),
    .sample (s_if),
    .result (r_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Predicted tracker state and configuration
  angle_t cfg_offset;
  logic   cfg_reverse;
  angle_t est_held;
  angle_t est_track;
  pos_t   est_pos;

  sample_t queued_samples[$];
  result_t awaited_positions[$];
  sample_t cur_item;
  angle_t  last_raw;
  int      gap_left;
  int      stall_left;
  int      mismatch_count;
  bit      idle_en;
  bit      sink_hold;

  always #10 clk = ~clk;

  function automatic angle_t correct_angle(angle_t raw);
    angle_t v;
    v = raw + cfg_offset;
    if (cfg_reverse) v = 12'd0 - v;
    return v;
  endfunction

  function automatic void step_position(angle_t v);
    int vi;
    int ti;
    int d;
    vi = int'(v);
    ti = int'(est_track);
    d = vi - ti;
    // unwrap across the zero crossing
    if (ti > HalfTurnI && vi < ti - HalfTurnI) d = d + FullTurnI;
    else if (vi > HalfTurnI && ti < vi - HalfTurnI) d = d - FullTurnI;
    est_pos = est_pos + pos_t'(d);
    est_track = v;
  endfunction

  function automatic result_t advance_tracker(sample_t s);
    result_t r;
    pos_t    prior_pos;
    pos_t    sh;
    prior_pos = est_pos;
    case (s.opcode)
      OP_SAMPLE: begin
        if (!s.read_error) begin
          est_held = correct_angle(s.enc_angle);
          step_position(est_held);
        end
      end
      OP_REUSE: step_position(est_held);
      OP_LOAD: est_pos = s.load_value;
      default: begin
        if (!s.read_error) est_held = correct_angle(s.enc_angle);
        est_track = est_held;
        est_pos = s.load_value;
      end
    endcase
    sh = (est_pos >>> 12) + (est_pos[PosW-1] ? 32'sd1 : 32'sd0);
    r.angle = est_held;
    r.position = est_pos;
    r.revolutions = rev_t'(sh[RevW-1:0]);
    r.previous_position = (s.opcode == OP_LOAD || s.opcode == OP_RESEED) ? prior_pos : est_pos;
    return r;
  endfunction

  task automatic offer_next();
    cur_item = queued_samples.pop_front();
    s_if.valid      <= 1'b1;
    s_if.opcode     <= cur_item.opcode;
    s_if.enc_angle  <= cur_item.enc_angle;
    s_if.read_error <= cur_item.read_error;
    s_if.load_value <= cur_item.load_value;
  endtask

  // Sample driver
  always @(posedge clk) begin
    int g;
    if (rst) begin
      s_if.valid <= 1'b0;
      gap_left <= 0;
    end else if (s_if.valid && s_if.ready) begin
      awaited_positions.push_back(advance_tracker(cur_item));
      g = idle_en ? $urandom_range(0, 13) : 0;
      if (g == 0 && queued_samples.size() > 0) begin
        offer_next();
      end else begin
        s_if.valid <= 1'b0;
        gap_left <= g;
      end
    end else if (!s_if.valid) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      else if (queued_samples.size() > 0) offer_next();
    end
  end

  // Result monitor and sink back-pressure
  always @(posedge clk) begin
    result_t got;
    result_t exp;
    int s;
    if (rst) begin
      r_if.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (r_if.valid && r_if.ready) begin
        got.angle = r_if.angle;
        got.position = r_if.position;
        got.revolutions = r_if.revolutions;
        got.previous_position = r_if.previous_position;
        if (awaited_positions.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: angle=%0d position=%0d revs=%0d prev=%0d",
                     got.angle, got.position, got.revolutions, got.previous_position);
        end else begin
          exp = awaited_positions.pop_front();
          if (got.angle !== exp.angle || got.position !== exp.position ||
              got.revolutions !== exp.revolutions ||
              got.previous_position !== exp.previous_position) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: expected angle=%0d position=%0d revs=%0d prev=%0d",
                       exp.angle, exp.position, exp.revolutions, exp.previous_position);
              $display("          actual   angle=%0d position=%0d revs=%0d prev=%0d",
                       got.angle, got.position, got.revolutions, got.previous_position);
            end
          end
        end
        s = idle_en ? $urandom_range(0, 13) : 0;
        r_if.ready <= (s == 0) && !sink_hold;
        stall_left <= s;
      end else if (sink_hold) begin
        r_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        r_if.ready <= 1'b0;
      end else begin
        r_if.ready <= 1'b1;
      end
    end
  end

  task automatic apb_write(input reg_idx_t idx, input logic [DataW-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ANGLE_OFFSET: cfg_offset = val[AngleW-1:0];
      default: cfg_reverse = val[0];
    endcase
  endtask

  task automatic set_config(input angle_t offset, input logic reverse);
    apb_write(REG_ANGLE_OFFSET, DataW'(offset));
    apb_write(REG_REVERSE_DIRECTION, DataW'(reverse));
  endtask

  task automatic queue_item(input opcode_t op, input angle_t raw, input logic err,
                            input pos_t load);
    sample_t s;
    s.opcode = op;
    s.enc_angle = raw;
    s.read_error = err;
    s.load_value = load;
    queued_samples.push_back(s);
  endtask

  function automatic sample_t random_item();
    sample_t s;
    int pick;
    int step;
    pick = $urandom_range(0, 99);
    s.enc_angle = angle_t'($urandom);
    s.read_error = ($urandom_range(0, 9) == 0);
    s.load_value = pos_t'($urandom);
    if (pick < 70) begin
      s.opcode = OP_SAMPLE;
      // mostly keep consecutive samples within half a turn
      if (pick < 60) begin
        step = int'($urandom_range(0, 4094)) - 2047;
        s.enc_angle = angle_t'(int'(last_raw) + step);
      end
    end else if (pick < 80) begin
      s.opcode = OP_REUSE;
    end else if (pick < 90) begin
      s.opcode = OP_LOAD;
    end else begin
      s.opcode = OP_RESEED;
    end
    if (pick >= 80 && $urandom_range(0, 3) == 0)
      s.load_value = $urandom_range(0, 1) ? pos_t'(32'h7FFF_F000 + $urandom_range(0, 4095))
                                          : pos_t'(32'h8000_0000 + $urandom_range(0, 4095));
    if ((s.opcode == OP_SAMPLE || s.opcode == OP_RESEED) && !s.read_error)
      last_raw = s.enc_angle;
    return s;
  endfunction

  task automatic wait_drained();
    while (queued_samples.size() > 0 || s_if.valid || awaited_positions.size() > 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input int count, input bit idle);
    @(negedge clk);
    idle_en = idle;
    repeat (count) queued_samples.push_back(random_item());
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_if.valid = 1'b0;
    s_if.opcode = OP_SAMPLE;
    s_if.enc_angle = '0;
    s_if.read_error = 1'b0;
    s_if.load_value = '0;
    r_if.ready = 1'b0;
    cfg_offset = '0;
    cfg_reverse = 1'b0;
    est_held = '0;
    est_track = '0;
    est_pos = '0;
    last_raw = '0;
    gap_left = 0;
    stall_left = 0;
    mismatch_count = 0;
    idle_en = 1'b1;
    sink_hold = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: half-turn boundaries, both wraps, bad reads, loads, overflow
    @(negedge clk);
    queue_item(OP_SAMPLE, 12'd0, 1'b0, 32'sd0);
    queue_item(OP_SAMPLE, 12'd2047, 1'b0, 32'sd0);
    queue_item(OP_SAMPLE, 12'd4095, 1'b0, 32'sd0);
    queue_item(OP_SAMPLE, 12'd2047, 1'b0, -32'sd1);
    queue_item(OP_SAMPLE, 12'd4000, 1'b0, 32'sd0);
    queue_item(OP_SAMPLE, 12'd10, 1'b0, 32'sd0);
    queue_item(OP_SAMPLE, 12'd4000, 1'b0, 32'sd0);
    queue_item(OP_SAMPLE, 12'd123, 1'b1, 32'sd0);
    queue_item(OP_REUSE, 12'd4095, 1'b1, -32'sd1);
    queue_item(OP_LOAD, 12'd4095, 1'b1, 32'sh7FFF_FFFF);
    queue_item(OP_SAMPLE, 12'd100, 1'b0, 32'sd0);
    queue_item(OP_LOAD, 12'd0, 1'b0, 32'sh8000_0000);
    queue_item(OP_SAMPLE, 12'd3000, 1'b0, 32'sd0);
    queue_item(OP_RESEED, 12'd500, 1'b1, -32'sd4096);
    queue_item(OP_RESEED, 12'd3500, 1'b0, -32'sd1);
    queue_item(OP_SAMPLE, 12'd3500, 1'b0, 32'sd0);
    queue_item(OP_LOAD, 12'd0, 1'b0, -32'sd4096);
    queue_item(OP_SAMPLE, 12'd3400, 1'b0, 32'sd0);
    queue_item(OP_LOAD, 12'd0, 1'b0, 32'sd4095);
    queue_item(OP_REUSE, 12'd0, 1'b0, 32'sd0);
    queue_item(OP_SAMPLE, 12'd4095, 1'b0, 32'shA5A5_5A5A);
    last_raw = 12'd4095;
    wait_drained();

    set_config(12'd4095, 1'b0);
    run_phase(150, 1'b1);

    set_config(12'd0, 1'b1);
    run_phase(150, 1'b0);

    // Long sink hold-off while the driver keeps offering samples
    set_config(angle_t'($urandom), 1'($urandom));
    @(negedge clk);
    idle_en = 1'b0;
    repeat (150) queued_samples.push_back(random_item());
    sink_hold = 1'b1;
    repeat (250) @(negedge clk);
    sink_hold = 1'b0;
    wait_drained();

    set_config(12'd4095, 1'b1);
    run_phase(150, 1'b1);

    set_config(angle_t'($urandom), 1'($urandom));
    run_phase(150, 1'b0);

    set_config(12'd0, 1'b0);
    run_phase(100, 1'b1);

    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && awaited_positions.size() == 0) begin
      $display("tb_multiturn_angle_position_tracker_core: PASS");
    end else begin
      $display("tb_multiturn_angle_position_tracker_core: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_multiturn_angle_position_tracker_core: FAIL");
    $finish;
  end

endmodule
